[rtl/core/olst_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// olst_pkg
// Shared types and constants for the ordered list store.
// ----------------------------------------------------------------------------
package olst_pkg;

   localparam int CAPACITY_DEF = 64;
   localparam int FUNC_W       = 2;
   localparam int VALUE_W      = 32;
   localparam int COUNT_OUT_W  = 7;

   localparam logic [FUNC_W-1:0] FUNC_APPEND  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_PREPEND = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_SEARCH  = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE  = 2'd3;

   // controller -> datapath
   typedef struct packed {
      logic capture;     // take the request transaction
      logic add_link;    // allocate a slot and link the new entry
      logic refuse;      // add into a full store
      logic miss;        // search/remove ended without a match
      logic walk_start;  // read the head entry
      logic walk_step;   // move to the next entry
      logic hit;         // match found (unlinks when removing)
      logic load_rsp;    // move the result into the output register
   } olst_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_add;
      logic full;
      logic empty;
      logic match;
      logic last;
   } olst_status_type;

endpackage
`default_nettype wire

[rtl/core/olst_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// olst_if
// Valid/ready channels for requests and responses of the ordered list store.
// ----------------------------------------------------------------------------
interface olst_req_if;
   import olst_pkg::*;

   logic                      valid;
   logic                      ready;
   logic [FUNC_W-1:0]         func;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, output func, output value, input ready);
   modport sink   (input valid, input func, input value, output ready);
endinterface

interface olst_rsp_if;
   import olst_pkg::*;

   logic                   valid;
   logic                   ready;
   logic                   found;
   logic                   accepted;
   logic [COUNT_OUT_W-1:0] entry_count;

   modport source (output valid, output found, output accepted, output entry_count,
                   input ready);
   modport sink   (input valid, input found, input accepted, input entry_count,
                   output ready);
endinterface
`default_nettype wire

[rtl/core/olst_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// olst_ctrl
// Sequencer: decodes a request, steps the list walk and hands the result on.
// ----------------------------------------------------------------------------
module olst_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   input  wire olst_pkg::olst_status_type status,
   output olst_pkg::olst_cmd_type         cmd
);
   import olst_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_DECODE = 4'b0010,
      ST_WALK   = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (status.is_add) begin
               if (status.full) begin
                  cmd.refuse = 1'b1;
               end else begin
                  cmd.add_link = 1'b1;
               end
               state_in = ST_FINISH;
            end else if (status.empty) begin
               cmd.miss = 1'b1;
               state_in = ST_FINISH;
            end else begin
               cmd.walk_start = 1'b1;
               state_in       = ST_WALK;
            end
         end
         ST_WALK: begin
            if (status.match) begin
               cmd.hit  = 1'b1;
               state_in = ST_FINISH;
            end else if (status.last) begin
               cmd.miss = 1'b1;
               state_in = ST_FINISH;
            end else begin
               cmd.walk_step = 1'b1;
            end
         end
         ST_FINISH: begin
            // wait for the output register to drain
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

[rtl/core/olst_dpath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// olst_dpath
// Slot storage, links, free-slot stack, head/tail/count and result registers.
// ----------------------------------------------------------------------------
module olst_dpath #(
   parameter int CAPACITY = olst_pkg::CAPACITY_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire olst_pkg::olst_cmd_type               cmd,
   output olst_pkg::olst_status_type                 status,
   input  wire logic [olst_pkg::FUNC_W-1:0]          req_func,
   input  wire logic signed [olst_pkg::VALUE_W-1:0]  req_value,
   output logic                                      rsp_found,
   output logic                                      rsp_accepted,
   output logic [olst_pkg::COUNT_OUT_W-1:0]          rsp_entry_count
);
   import olst_pkg::*;

   localparam int SLOT_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int COUNT_W = $clog2(CAPACITY + 1);
   localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(CAPACITY);

   // storage
   logic signed [VALUE_W-1:0] val_mem  [CAPACITY];
   logic [SLOT_W-1:0]         link_mem [CAPACITY];
   logic [SLOT_W-1:0]         stk_mem  [CAPACITY];

   logic signed [VALUE_W-1:0] val_rd_ff;
   logic [SLOT_W-1:0]         link_rd_ff;
   logic [SLOT_W-1:0]         stk_rd_ff;

   logic [FUNC_W-1:0]         func_ff;
   logic signed [VALUE_W-1:0] value_ff;
   logic [SLOT_W-1:0]         head_ff, head_in;
   logic [SLOT_W-1:0]         tail_ff, tail_in;
   logic [COUNT_W-1:0]        count_ff, count_in;
   logic [COUNT_W-1:0]        fresh_ff, fresh_in;   // slots never used so far
   logic [COUNT_W-1:0]        sp_ff, sp_in;         // depth of the free stack
   logic [SLOT_W-1:0]         cur_ff, prev_ff;
   logic [SLOT_W-1:0]         idx_ff;
   logic                      found_ff, accepted_ff;
   logic                      rsp_found_ff, rsp_accepted_ff;
   logic [COUNT_W-1:0]        rsp_count_ff;

   logic [SLOT_W-1:0]         new_slot;
   logic [SLOT_W-1:0]         rd_addr;
   logic [SLOT_W-1:0]         stk_rd_addr;
   logic                      link_we;
   logic [SLOT_W-1:0]         link_wa, link_wd;
   logic                      is_prepend, is_remove;

   assign is_prepend = (func_ff == FUNC_PREPEND);
   assign is_remove  = (func_ff == FUNC_REMOVE);

   // recycled slots first, then untouched ones
   assign new_slot    = (sp_ff != '0) ? stk_rd_ff : fresh_ff[SLOT_W-1:0];
   assign stk_rd_addr = SLOT_W'(sp_ff - COUNT_W'(1));

   always_comb begin
      if (cmd.walk_start) begin
         rd_addr = head_ff;
      end else if (cmd.walk_step) begin
         rd_addr = link_rd_ff;
      end else begin
         rd_addr = cur_ff;
      end
   end

   always_comb begin
      link_we = 1'b0;
      link_wa = new_slot;
      link_wd = head_ff;
      if (cmd.add_link && count_ff != '0) begin
         link_we = 1'b1;
         if (is_prepend) begin
            link_wa = new_slot;
            link_wd = head_ff;
         end else begin
            link_wa = tail_ff;
            link_wd = new_slot;
         end
      end else if (cmd.hit && is_remove && idx_ff != '0) begin
         link_we = 1'b1;
         link_wa = prev_ff;
         link_wd = link_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.add_link) begin
         val_mem[new_slot] <= value_ff;
      end
      val_rd_ff <= val_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_wa] <= link_wd;
      end
      link_rd_ff <= link_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.hit && is_remove) begin
         stk_mem[sp_ff[SLOT_W-1:0]] <= cur_ff;
      end
      stk_rd_ff <= stk_mem[stk_rd_addr];
   end

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      fresh_in = fresh_ff;
      sp_in    = sp_ff;
      if (cmd.add_link) begin
         count_in = count_ff + COUNT_W'(1);
         if (sp_ff != '0) begin
            sp_in = sp_ff - COUNT_W'(1);
         end else begin
            fresh_in = fresh_ff + COUNT_W'(1);
         end
         if (count_ff == '0) begin
            head_in = new_slot;
            tail_in = new_slot;
         end else if (is_prepend) begin
            head_in = new_slot;
         end else begin
            tail_in = new_slot;
         end
      end else if (cmd.hit && is_remove) begin
         count_in = count_ff - COUNT_W'(1);
         sp_in    = sp_ff + COUNT_W'(1);
         if (idx_ff == '0) begin
            head_in = link_rd_ff;
         end
         if (status.last) begin
            tail_in = prev_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
         fresh_ff <= '0;
         sp_ff    <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         fresh_ff <= fresh_in;
         sp_ff    <= sp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff  <= req_func;
         value_ff <= req_value;
      end
      if (cmd.walk_start) begin
         cur_ff <= head_ff;
         idx_ff <= '0;
      end else if (cmd.walk_step) begin
         prev_ff <= cur_ff;
         cur_ff  <= link_rd_ff;
         idx_ff  <= idx_ff + SLOT_W'(1);
      end
      if (cmd.refuse || cmd.miss) begin
         found_ff    <= 1'b0;
         accepted_ff <= 1'b0;
      end else if (cmd.add_link) begin
         found_ff    <= 1'b0;
         accepted_ff <= 1'b1;
      end else if (cmd.hit) begin
         found_ff    <= 1'b1;
         accepted_ff <= 1'b1;
      end
      if (cmd.load_rsp) begin
         rsp_found_ff    <= found_ff;
         rsp_accepted_ff <= accepted_ff;
         rsp_count_ff    <= count_ff;
      end
   end

   assign status.is_add = (func_ff == FUNC_APPEND) || (func_ff == FUNC_PREPEND);
   assign status.full   = (count_ff == COUNT_FULL);
   assign status.empty  = (count_ff == '0);
   assign status.match  = (val_rd_ff == value_ff);
   assign status.last   = ((COUNT_W'(idx_ff) + COUNT_W'(1)) == count_ff);

   assign rsp_found       = rsp_found_ff;
   assign rsp_accepted    = rsp_accepted_ff;
   assign rsp_entry_count = COUNT_OUT_W'(rsp_count_ff);

endmodule
`default_nettype wire

[rtl/core/ordered_list_store.sv]
`default_nettype none
// Append/prepend: the request is taken, decoded (a slot linked in, or refused
// when full) and the result loaded into the output register. Search/remove:
// the walk reads one linked entry per cycle from the head until a match or the
// last entry; an empty list misses at decode. A new request is taken only once
// the previous result is loaded; a response left waiting on rsp_ch.ready stalls the next in finish.
// Synchronous reset empties the list at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
// ordered_list_store
// Ordered sequence of signed values kept as a linked list over slot memories.
// ----------------------------------------------------------------------------
module ordered_list_store #(
   parameter int CAPACITY = olst_pkg::CAPACITY_DEF
) (
   input wire logic    clock,
   input wire logic    reset,
   olst_req_if.sink    req_ch,
   olst_rsp_if.source  rsp_ch
);
   import olst_pkg::*;

   olst_cmd_type    cmd;
   olst_status_type status;

   olst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   olst_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_func        (req_ch.func),
      .req_value       (req_ch.value),
      .rsp_found       (rsp_ch.found),
      .rsp_accepted    (rsp_ch.accepted),
      .rsp_entry_count (rsp_ch.entry_count)
   );

endmodule
`default_nettype wire
